// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the queue and output-stage RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication that must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== sv/c2u_pkg.sv =====
package c2u_pkg;

	localparam logic [7:0] C1_FIRST     = 8'h80;
	localparam logic [7:0] C1_LAST      = 8'h9F;
	localparam logic [7:0] LATIN1_FIRST = 8'hA0;

	localparam int unsigned MAX_BYTES = 3;
	localparam int unsigned Q_DEPTH   = 2;
	localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
	localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

	localparam logic [1:0] CNT_ONE   = 2'd1;
	localparam logic [1:0] CNT_TWO   = 2'd2;
	localparam logic [1:0] CNT_THREE = 2'd3;

	// One classified item: the UTF-8 bytes in output order and how many are used.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [1:0]                cnt;
	} desc_t;

	// Code points for 0x80..0x9F; zero marks an undefined code.
	function automatic logic [15:0] c1_code_point(input logic [4:0] idx);
		logic [15:0] cp;
		case (idx)
			5'h00: cp = 16'h20AC;
			5'h02: cp = 16'h201A;
			5'h03: cp = 16'h0192;
			5'h04: cp = 16'h201E;
			5'h05: cp = 16'h2026;
			5'h06: cp = 16'h2020;
			5'h07: cp = 16'h2021;
			5'h08: cp = 16'h02C6;
			5'h09: cp = 16'h2030;
			5'h0A: cp = 16'h0160;
			5'h0B: cp = 16'h2039;
			5'h0C: cp = 16'h0152;
			5'h0E: cp = 16'h017D;
			5'h11: cp = 16'h2018;
			5'h12: cp = 16'h2019;
			5'h13: cp = 16'h201C;
			5'h14: cp = 16'h201D;
			5'h15: cp = 16'h2022;
			5'h16: cp = 16'h2013;
			5'h17: cp = 16'h2014;
			5'h18: cp = 16'h02DC;
			5'h19: cp = 16'h2122;
			5'h1A: cp = 16'h0161;
			5'h1B: cp = 16'h203A;
			5'h1C: cp = 16'h0153;
			5'h1E: cp = 16'h017E;
			5'h1F: cp = 16'h0178;
			default: cp = 16'h0000;
		endcase
		return cp;
	endfunction

endpackage

// ===== sv/c2u_front.sv =====
module c2u_front (
	input  logic                 push,
	input  logic [7:0]           code_byte,
	input  logic                 q_full,
	output logic                 full,
	output logic                 q_push,
	output c2u_pkg::desc_t       q_desc
);
	import c2u_pkg::*;

	logic [15:0] cp;
	logic        pass_through;

	assign full   = q_full;
	assign q_push = push && !q_full;

	always_comb begin
		cp           = {8'h00, code_byte};
		pass_through = 1'b0;
		if (code_byte < C1_FIRST) begin
			pass_through = 1'b1;
		end else if (code_byte inside {[C1_FIRST:C1_LAST]}) begin
			cp = c1_code_point(code_byte[4:0]);
			// undefined codes go out unchanged
			if (cp == 16'h0000) pass_through = 1'b1;
		end
	end

	always_comb begin
		q_desc = '0;
		if (pass_through) begin
			q_desc.bytes[0] = code_byte;
			q_desc.cnt      = CNT_ONE;
		end else if (cp < 16'h0800) begin
			q_desc.bytes[0] = {3'b110, cp[10:6]};
			q_desc.bytes[1] = {2'b10, cp[5:0]};
			q_desc.cnt      = CNT_TWO;
		end else begin
			q_desc.bytes[0] = {4'b1110, cp[15:12]};
			q_desc.bytes[1] = {2'b10, cp[11:6]};
			q_desc.bytes[2] = {2'b10, cp[5:0]};
			q_desc.cnt      = CNT_THREE;
		end
	end

endmodule

// ===== sv/c2u_queue.sv =====
`include "assert_macros.svh"

module c2u_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  c2u_pkg::desc_t wr_desc,
	input  logic           rd_en,
	output c2u_pkg::desc_t rd_desc,
	output logic           q_full,
	output logic           q_empty
);
	import c2u_pkg::*;

	desc_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                do_wr;
	logic                do_rd;

	assign q_full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_desc = mem_q[rd_ptr_q];
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_CLK(a_q_count_bound, clk, arst_n, count_q <= Q_CNT_W'(Q_DEPTH), "queue count overflow")
	`ASSERT_NEXT(a_q_fill, clk, arst_n, do_wr && !do_rd, !q_empty, "queue lost a written item")

endmodule

// ===== sv/c2u_back.sv =====
`include "assert_macros.svh"

module c2u_back (
	input  logic           clk,
	input  logic           arst_n,
	input  c2u_pkg::desc_t rd_desc,
	input  logic           q_empty,
	output logic           rd_en,
	input  logic           pop,
	output logic           empty,
	output logic [7:0]     utf8_byte,
	output logic           last_of_run
);
	import c2u_pkg::*;

	desc_t       cur_q;
	logic        valid_q;
	logic [1:0]  idx_q;
	logic        take;
	logic        done;

	assign empty       = !valid_q;
	assign utf8_byte   = cur_q.bytes[idx_q];
	assign last_of_run = (idx_q == cur_q.cnt - 2'd1);
	assign take        = pop && valid_q;
	assign done        = !valid_q || (take && last_of_run);
	// next item loads as soon as the current run is finished
	assign rd_en       = done && !q_empty;

	always_ff @(posedge clk) begin
		if (rd_en) cur_q <= rd_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (done) begin
			valid_q <= !q_empty;
			idx_q   <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	`ASSERT_CLK(a_idx_in_run, clk, arst_n, !valid_q || (idx_q < cur_q.cnt),
		"byte index past end of run")
	`ASSERT_NEXT(a_run_continues, clk, arst_n, take && !last_of_run, valid_q && (idx_q != 2'd0),
		"run dropped before its last byte")

endmodule

// ===== sv/cp1252_to_utf8_transcoder_unit.sv =====
// Windows-1252 to UTF-8 transcoder. Each pushed item is one Windows-1252 byte;
// the result queue yields its UTF-8 encoding as one to three bytes, in order,
// with last_of_run set on the final byte. Undefined codes 0x81, 0x8D, 0x8F,
// 0x90 and 0x9D pass through as a single unchanged byte. The input side takes
// one item per cycle while the two-entry internal queue has room; the output
// stage issues one byte per cycle while pop is held, and loads the next item
// as the last byte of the current one is popped. A result is written into the
// queue and then into the output stage register before it is visible. No
// configuration and no state beyond the queue and the output stage.
module cp1252_to_utf8_transcoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] code_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] utf8_byte,
	output logic       last_of_run
);
	import c2u_pkg::*;

	desc_t q_desc;
	desc_t rd_desc;
	logic  q_push;
	logic  q_full;
	logic  q_empty;
	logic  rd_en;

	c2u_front u_front (
		.push      (push),
		.code_byte (code_byte),
		.q_full    (q_full),
		.full      (full),
		.q_push    (q_push),
		.q_desc    (q_desc)
	);

	c2u_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_desc (q_desc),
		.rd_en   (rd_en),
		.rd_desc (rd_desc),
		.q_full  (q_full),
		.q_empty (q_empty)
	);

	c2u_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_desc     (rd_desc),
		.q_empty     (q_empty),
		.rd_en       (rd_en),
		.pop         (pop),
		.empty       (empty),
		.utf8_byte   (utf8_byte),
		.last_of_run (last_of_run)
	);

endmodule

// ===== tb/sv/tb_cp1252_to_utf8_transcoder_unit.sv =====
module tb_cp1252_to_utf8_transcoder_unit;
	import c2u_pkg::*;

	localparam int unsigned RANDOM_CODES  = 480;
	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam int unsigned LONG_HOLD     = 90;
	localparam int unsigned HOLD_AT_CODE  = 150;
	localparam int unsigned DRAIN_AT_CODE = 320;
	localparam int unsigned TAIL_CYCLES   = 8;
	localparam logic [15:0] TWO_BYTE_END  = 16'h0800;
	localparam logic [15:0] NO_MAPPING    = 16'h0000;
	localparam logic [7:0]  LEAD_TWO      = 8'hC0;
	localparam logic [7:0]  LEAD_THREE    = 8'hE0;
	localparam logic [7:0]  CONT_MARK     = 8'h80;
	localparam logic [7:0]  ASCII_LAST    = 8'h7F;
	localparam logic [7:0]  CODE_LAST     = 8'hFF;

	typedef struct {
		logic [7:0] value;
		logic       last;
	} utf8_out_t;

	class utf8_run_tracker;
		utf8_out_t   pending_bytes[$];
		logic [15:0] c1_points[32];
		int unsigned mismatch_count;

		function new();
			c1_points = '{
				16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
				16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
				16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
				16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178
			};
			mismatch_count = 0;
		endfunction

		function void add_byte(input logic [7:0] value, input logic last);
			utf8_out_t b;
			b.value = value;
			b.last  = last;
			pending_bytes.push_back(b);
		endfunction

		// Queue the UTF-8 run for one accepted Windows-1252 code.
		function void note_code(input logic [7:0] code);
			logic [15:0] cp;
			cp = {8'h00, code};
			if (code >= C1_FIRST && code <= C1_LAST)
				cp = c1_points[code[4:0]];
			// ASCII and unmapped C1 codes go out as the byte itself
			if (code < C1_FIRST || cp == NO_MAPPING) begin
				add_byte(code, 1'b1);
			end else if (cp < TWO_BYTE_END) begin
				add_byte(LEAD_TWO | {3'b000, cp[10:6]}, 1'b0);
				add_byte(CONT_MARK | {2'b00, cp[5:0]}, 1'b1);
			end else begin
				add_byte(LEAD_THREE | {4'h0, cp[15:12]}, 1'b0);
				add_byte(CONT_MARK | {2'b00, cp[11:6]}, 1'b0);
				add_byte(CONT_MARK | {2'b00, cp[5:0]}, 1'b1);
			end
		endfunction

		function void check_byte(input logic [7:0] value, input logic last);
			utf8_out_t want;
			if (pending_bytes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected byte: utf8_byte=%02h last_of_run=%0b", value, last);
				return;
			end
			want = pending_bytes.pop_front();
			if (value !== want.value || last !== want.last) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("mismatch: expected %02h/%0b, got %02h/%0b",
						want.value, want.last, value, last);
			end
		endfunction

		function int unsigned outstanding();
			return pending_bytes.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] code_byte;
	logic       empty;
	logic       pop;
	logic [7:0] utf8_byte;
	logic       last_of_run;

	utf8_run_tracker runs = new();
	int unsigned     cycle_count = 0;
	int unsigned     rx_hold_left = 0;

	cp1252_to_utf8_transcoder_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.code_byte   (code_byte),
		.empty       (empty),
		.pop         (pop),
		.utf8_byte   (utf8_byte),
		.last_of_run (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Values read here are the ones present just before the edge.
	always @(posedge clk) begin
		if (arst_n && push && !full)
			runs.note_code(code_byte);
		if (arst_n && pop && !empty)
			runs.check_byte(utf8_byte, last_of_run);
	end

	// Receiver: pop rate is redrawn at the start of each window; a requested hold overrides it.
	initial begin
		int unsigned pop_pct;
		int unsigned window;
		pop <= 1'b0;
		pop_pct = 100;
		window = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				pop <= 1'b0;
				rx_hold_left--;
			end else begin
				if (window == 0) begin
					case ($urandom_range(0, 4))
						0, 1: pop_pct = 100;
						2: pop_pct = 75;
						3: pop_pct = 40;
						default: pop_pct = 15;
					endcase
					window = 40;
				end
				window--;
				pop <= ($urandom_range(0, 99) < pop_pct);
			end
		end
	end

	task automatic send_code(input logic [7:0] code);
		push <= 1'b1;
		code_byte <= code;
		do @(posedge clk); while (full);
	endtask

	task automatic rest_sender(input int unsigned cycles);
		push <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (runs.outstanding() != 0);
	endtask

	function automatic logic [7:0] pick_code();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, CODE_LAST));
			1: return 8'($urandom_range(C1_FIRST, C1_LAST));
			2: return 8'($urandom_range(LATIN1_FIRST, CODE_LAST));
			default: return 8'($urandom_range(0, ASCII_LAST));
		endcase
	endfunction

	initial begin
		logic [7:0]  directed[] = '{
			8'h00, 8'h7F, 8'h41, C1_FIRST, 8'h81, 8'h8D, 8'h8F, 8'h90, 8'h9D,
			8'h98, 8'h8A, 8'h99, C1_LAST, LATIN1_FIRST, 8'hAD, 8'hC3, CODE_LAST,
			8'h55, 8'hAA, 8'h83, 8'h8C, 8'h9E
		};
		int unsigned sent;
		int unsigned burst;
		arst_n    <= 1'b0;
		push      <= 1'b0;
		code_byte <= 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_code(directed[i]);
			if ($urandom_range(0, 3) == 0)
				rest_sender($urandom_range(1, 3));
		end
		drain_results();

		sent = 0;
		while (sent < RANDOM_CODES) begin
			burst = $urandom_range(1, 24);
			for (int unsigned k = 0; k < burst && sent < RANDOM_CODES; k++) begin
				send_code(pick_code());
				sent++;
				// long receiver stall while items keep coming: input side must back up
				if (sent == HOLD_AT_CODE)
					rx_hold_left = LONG_HOLD;
				if (sent == DRAIN_AT_CODE)
					drain_results();
			end
			if ($urandom_range(0, 4) != 0)
				rest_sender($urandom_range(1, 8));
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (runs.mismatch_count == 0 && runs.outstanding() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/c2u_pkg.sv
sv/c2u_front.sv
sv/c2u_queue.sv
sv/c2u_back.sv
sv/cp1252_to_utf8_transcoder_unit.sv
tb/sv/tb_cp1252_to_utf8_transcoder_unit.sv
